// ===== hw/rtl/vsl_pkg.sv =====
// Shared types for the vector set-length pipeline.
// Holds the stage records passed between the square-root and divide stages.
// Depends on nothing.
package vsl_pkg;

  localparam int unsigned RootBits = 32;

  // Sign and magnitude of one vector request plus its target length.
  typedef struct packed {
    logic        neg_x;
    logic        neg_y;
    logic [31:0] ax;
    logic [31:0] ay;
    logic [30:0] len;
  } vsl_vec_t;

  // One step of the digit-by-digit square root.
  typedef struct packed {
    vsl_vec_t    vec;
    logic [63:0] rad;
    logic [31:0] root;
    logic [34:0] rem;
  } vsl_sqrt_t;

  // One step of the two restoring dividers that share a divisor.
  typedef struct packed {
    logic        neg_x;
    logic        neg_y;
    logic [31:0] m;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] nx;
    logic [31:0] ny;
    logic [31:0] qx;
    logic [31:0] qy;
  } vsl_div_t;

endpackage

// ===== hw/rtl/vector_set_length.sv =====
// Vector set-length: scales (in_x, in_y) to target_length, in fixed point.
// Pipeline from request to result: input, square, sum, 32 root stages, round,
// multiply, 32 divide stages, output. One request is taken every cycle; a stall
// at the output freezes the whole pipeline.
// Synchronous reset clears all valid bits; payload registers are not reset.
// Depends on vsl_pkg, vsl_sqrt_stage and vsl_div_stage.
module vector_set_length (
  input  logic               clk,
  input  logic               rst,
  input  logic               valid_in,
  output logic               stall_in,
  input  logic signed [31:0] in_x,
  input  logic signed [31:0] in_y,
  input  logic [30:0]        target_length,
  output logic               valid_out,
  input  logic               stall_out,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic               ok,
  output logic [31:0]        vec_length
);

  localparam int unsigned NRoot = vsl_pkg::RootBits;

  logic en;

  // Pipeline advances unless a finished result is held by the receiver.
  assign en       = !(valid_out && stall_out);
  assign stall_in = !en;

  // Input stage: sign and magnitude.
  logic              v0;
  vsl_pkg::vsl_vec_t s0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0.neg_x <= in_x[31];
      s0.neg_y <= in_y[31];
      s0.ax    <= in_x[31] ? 32'(-in_x) : in_x;
      s0.ay    <= in_y[31] ? 32'(-in_y) : in_y;
      s0.len   <= target_length;
    end
  end

  // Square stage.
  logic              v1;
  vsl_pkg::vsl_vec_t s1;
  logic [63:0]       sqx;
  logic [63:0]       sqy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1  <= s0;
      sqx <= s0.ax * s0.ax;
      sqy <= s0.ay * s0.ay;
    end
  end

  // Sum stage feeds the root chain.
  logic              v2;
  vsl_pkg::vsl_sqrt_t s2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2.vec  <= s1;
      s2.rad  <= sqx + sqy;
      s2.root <= '0;
      s2.rem  <= '0;
    end
  end

  // Square root chain, one root bit per stage.
  logic               rv [NRoot+1];
  vsl_pkg::vsl_sqrt_t rd [NRoot+1];

  assign rv[0] = v2;
  assign rd[0] = s2;

  for (genvar i = 0; i < NRoot; i++) begin : g_root
    vsl_sqrt_stage u_stage (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .v_in  (rv[i]),
      .d_in  (rd[i]),
      .v_out (rv[i+1]),
      .d_out (rd[i+1])
    );
  end

  // Round the root to nearest.
  logic              v3;
  vsl_pkg::vsl_vec_t s3;
  logic [31:0]       m3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= rv[NRoot];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3 <= rd[NRoot].vec;
      m3 <= rd[NRoot].root +
            32'(rd[NRoot].rem > {3'b000, rd[NRoot].root});
    end
  end

  // Multiply each magnitude by the target length.
  logic        v4;
  logic        neg_x4;
  logic        neg_y4;
  logic [31:0] m4;
  logic [62:0] prod_x;
  logic [62:0] prod_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_x4 <= s3.neg_x;
      neg_y4 <= s3.neg_y;
      m4     <= m3;
      prod_x <= 63'(s3.ax * s3.len);
      prod_y <= 63'(s3.ay * s3.len);
    end
  end

  // Add half the divisor for rounding and load the dividers.
  logic [62:0]       num_x;
  logic [62:0]       num_y;
  vsl_pkg::vsl_div_t div_in;
  logic              dv [NRoot+1];
  vsl_pkg::vsl_div_t dd [NRoot+1];

  always_comb begin
    num_x = prod_x + {32'd0, m4[31:1]};
    num_y = prod_y + {32'd0, m4[31:1]};
    div_in.neg_x = neg_x4;
    div_in.neg_y = neg_y4;
    div_in.m     = m4;
    div_in.px    = {1'b0, num_x[62:32]};
    div_in.py    = {1'b0, num_y[62:32]};
    div_in.nx    = num_x[31:0];
    div_in.ny    = num_y[31:0];
    div_in.qx    = '0;
    div_in.qy    = '0;
  end

  assign dv[0] = v4;
  assign dd[0] = div_in;

  for (genvar i = 0; i < NRoot; i++) begin : g_div
    vsl_div_stage u_stage (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .v_in  (dv[i]),
      .d_in  (dd[i]),
      .v_out (dv[i+1]),
      .d_out (dd[i+1])
    );
  end

  // Failure checks and signed result.
  vsl_pkg::vsl_div_t df;
  logic              bad;

  always_comb begin
    df  = dd[NRoot];
    bad = (df.m == '0) ||
          (!df.neg_x && df.qx > 32'h7FFF_FFFF) ||
          (df.neg_x && df.qx > 32'h8000_0000) ||
          (!df.neg_y && df.qy > 32'h7FFF_FFFF) ||
          (df.neg_y && df.qy > 32'h8000_0000) ||
          (df.qx == '0 && df.qy == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= dv[NRoot];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (bad) begin
        out_x      <= '0;
        out_y      <= '0;
        ok         <= 1'b0;
        vec_length <= '0;
      end else begin
        out_x      <= df.neg_x ? 32'(-df.qx) : df.qx;
        out_y      <= df.neg_y ? 32'(-df.qy) : df.qy;
        ok         <= 1'b1;
        vec_length <= df.m;
      end
    end
  end

  // A failed result is all zeros.
  assert property (@(posedge clk) disable iff (rst)
    (valid_out && !ok) |-> (out_x == '0 && out_y == '0 && vec_length == '0))
    else $error("failed result not cleared");

  // A good result has a nonzero magnitude and a nonzero component.
  assert property (@(posedge clk) disable iff (rst)
    (valid_out && ok) |-> (vec_length != '0 && (out_x != '0 || out_y != '0)))
    else $error("good result with zero magnitude or vector");

  // Input is held off exactly when the output is held.
  assert property (@(posedge clk) disable iff (rst)
    stall_in == (valid_out && stall_out))
    else $error("input stall does not follow output hold");

  // A held pipeline keeps the valid bit of its last root stage.
  assert property (@(posedge clk) disable iff (rst)
    $past(!en) |-> $stable(rv[NRoot]))
    else $error("pipeline moved while held");

endmodule

// ===== hw/rtl/vsl_sqrt_stage.sv =====
// One registered stage of the square root: resolves one root bit.
// Depends on vsl_pkg.
module vsl_sqrt_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                v_in,
  input  vsl_pkg::vsl_sqrt_t  d_in,
  output logic                v_out,
  output vsl_pkg::vsl_sqrt_t  d_out
);

  logic [34:0]        r;
  logic [34:0]        t;
  vsl_pkg::vsl_sqrt_t d_next;

  // Bring in two radicand bits and try to subtract 4*root + 1.
  always_comb begin
    r      = {d_in.rem[32:0], d_in.rad[63:62]};
    t      = {1'b0, d_in.root, 2'b01};
    d_next = d_in;
    d_next.rad = {d_in.rad[61:0], 2'b00};
    if (r >= t) begin
      d_next.rem  = r - t;
      d_next.root = {d_in.root[30:0], 1'b1};
    end else begin
      d_next.rem  = r;
      d_next.root = {d_in.root[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (en) begin
      v_out <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= d_next;
    end
  end

endmodule

// ===== hw/rtl/vsl_div_stage.sv =====
// One registered stage of the two restoring dividers: one quotient bit each.
// Depends on vsl_pkg.
module vsl_div_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               v_in,
  input  vsl_pkg::vsl_div_t  d_in,
  output logic               v_out,
  output vsl_pkg::vsl_div_t  d_out
);

  logic [32:0]       tx;
  logic [32:0]       ty;
  logic [32:0]       dm;
  vsl_pkg::vsl_div_t d_next;

  // Shift in the next dividend bit and subtract the divisor where it fits.
  always_comb begin
    tx     = {d_in.px, d_in.nx[31]};
    ty     = {d_in.py, d_in.ny[31]};
    dm     = {1'b0, d_in.m};
    d_next = d_in;
    d_next.nx = {d_in.nx[30:0], 1'b0};
    d_next.ny = {d_in.ny[30:0], 1'b0};
    if (tx >= dm) begin
      d_next.px = 32'(tx - dm);
      d_next.qx = {d_in.qx[30:0], 1'b1};
    end else begin
      d_next.px = tx[31:0];
      d_next.qx = {d_in.qx[30:0], 1'b0};
    end
    if (ty >= dm) begin
      d_next.py = 32'(ty - dm);
      d_next.qy = {d_in.qy[30:0], 1'b1};
    end else begin
      d_next.py = ty[31:0];
      d_next.qy = {d_in.qy[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (en) begin
      v_out <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= d_next;
    end
  end

endmodule

// ===== sim/vector_set_length_tb.sv =====
// Testbench for vector_set_length: random and directed vector requests with a
// self-contained fixed-point predictor, random idling on both sides and checks.
// Depends on the vector_set_length RTL only.
module vector_set_length_tb;

  localparam int unsigned RandomCount = 1800;
  localparam int unsigned PipeLatency = 70;

  // One request and one expected result.
  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [30:0]        len;
  } vec_req_t;

  typedef struct {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic               good;
    logic [31:0]        mag;
  } vec_res_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               valid_in = 1'b0;
  logic               stall_in;
  logic signed [31:0] in_x = '0;
  logic signed [31:0] in_y = '0;
  logic [30:0]        target_length = '0;
  logic               valid_out;
  logic               stall_out = 1'b0;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic               ok;
  logic [31:0]        vec_length;

  vec_req_t pending_reqs[$];
  vec_res_t expected_results[$];
  int unsigned mismatch_count = 0;
  bit          stimulus_done = 1'b0;
  bit          quiet_mode = 1'b0;
  bit          drain_pause = 1'b0;
  bit          in_taken = 1'b0;
  bit          long_hold_done = 1'b0;
  int unsigned hold_cycles = 0;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;

  vector_set_length dut (.*);

  always #10 clk = ~clk;

  // Nearest-integer square root of a sum of two squares.
  function automatic logic [63:0] round_sqrt(logic [63:0] s);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] bit_val;
    rem = s;
    root = 0;
    bit_val = 64'd1 << 62;
    while (bit_val > rem) bit_val = bit_val >> 2;
    while (bit_val != 0) begin
      if (rem >= root + bit_val) begin
        rem = rem - (root + bit_val);
        root = (root >> 1) + bit_val;
      end else begin
        root = root >> 1;
      end
      bit_val = bit_val >> 2;
    end
    if (rem > root) root = root + 1;
    return root;
  endfunction

  // Scales one component by len / m, rounding half away from zero.
  function automatic logic signed [63:0] scale_component(logic signed [31:0] c,
      logic [30:0] len, logic [63:0] m, ref bit bad);
    logic        neg;
    logic [63:0] mag;
    logic [63:0] q;
    neg = c < 0;
    mag = neg ? 64'(-64'(c)) : 64'(c);
    q = (mag * 64'(len) + (m >> 1)) / m;
    if ((!neg && q > 64'h7FFF_FFFF) || (neg && q > 64'h8000_0000)) begin
      bad = 1'b1;
      return 0;
    end
    return neg ? -$signed(q) : $signed(q);
  endfunction

  // Predicts the rescaled vector for one request.
  function automatic vec_res_t predict_rescale(vec_req_t r);
    vec_res_t    res;
    logic [63:0] ax;
    logic [63:0] ay;
    logic [63:0] m;
    logic signed [63:0] sx;
    logic signed [63:0] sy;
    bit          bad;
    ax = r.x < 0 ? 64'(-64'(r.x)) : 64'(r.x);
    ay = r.y < 0 ? 64'(-64'(r.y)) : 64'(r.y);
    m = round_sqrt(ax * ax + ay * ay);
    bad = 1'b0;
    sx = 0;
    sy = 0;
    if (m == 0) begin
      bad = 1'b1;
    end else begin
      sx = scale_component(r.x, r.len, m, bad);
      sy = scale_component(r.y, r.len, m, bad);
      if (sx == 0 && sy == 0) bad = 1'b1;
    end
    if (bad) begin
      res = '{sx: 0, sy: 0, good: 1'b0, mag: 0};
    end else begin
      res = '{sx: sx[31:0], sy: sy[31:0], good: 1'b1, mag: m[31:0]};
    end
    return res;
  endfunction

  function automatic logic signed [31:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return $signed($urandom());
      1: return $signed($urandom_range(0, 65535)) - 32'sd32768;
      2: return $signed($urandom()) >>> $urandom_range(0, 31);
      3: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      4: return 0;
      default: return $signed($urandom_range(0, 1 << 22)) - 32'sd2097152;
    endcase
  endfunction

  function automatic logic [30:0] rand_len();
    case ($urandom_range(0, 4))
      0: return 31'(1 << 16);
      1: return 31'($urandom());
      2: return 31'($urandom_range(0, 8));
      3: return 31'h7FFF_FFFF;
      default: return 31'($urandom() >> $urandom_range(0, 30));
    endcase
  endfunction

  task automatic add_req(logic signed [31:0] x, logic signed [31:0] y, logic [30:0] len);
    pending_reqs.push_back('{x: x, y: y, len: len});
  endtask

  // Fill the request queue: directed corners first, then random vectors.
  initial begin
    add_req(0, 0, 31'(1 << 16));
    add_req(0, 0, 31'h7FFF_FFFF);
    add_req(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 31'h7FFF_FFFF);
    add_req(32'sh8000_0000, 32'sh8000_0000, 31'h7FFF_FFFF);
    add_req(32'sh8000_0000, 32'sh8000_0000, 31'(1 << 16));
    add_req(32'sh8000_0000, 0, 31'h7FFF_FFFF);
    add_req(0, 32'sh7FFF_FFFF, 31'(1 << 16));
    add_req(3 << 16, 4 << 16, 31'(1 << 16));
    add_req(-(3 << 16), 4 << 16, 31'(10 << 16));
    add_req(3 << 16, -(4 << 16), 0);
    add_req(1 << 16, 1 << 16, 1);
    add_req(1, 0, 31'h7FFF_FFFF);
    add_req(-1, -1, 31'h7FFF_FFFF);
    add_req(-1, 0, 1);
    add_req(32'sh7FFF_FFFF, 1, 2);
    add_req(5, -7, 31'(1 << 16));
    add_req(32'sh5555_5555, 32'shAAAA_AAAA, 31'h2AAA_AAAA);
    add_req(32'shAAAA_AAAA, 32'sh5555_5555, 31'h5555_5555);
    for (int i = 0; i < RandomCount; i++) add_req(rand_comp(), rand_comp(), rand_len());
  end

  // Reset, then watch for the end of stimulus and drain.
  initial begin
    int unsigned settle;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    wait (stimulus_done);
    wait (expected_results.size() == 0);
    settle = 0;
    while (settle < PipeLatency + 10) begin
      @(posedge clk);
      settle++;
    end
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #(20 * 600000);
    $display("FAILURE");
    $finish;
  end

  // Records whether the offered request was taken at this rising edge.
  always @(posedge clk) begin
    in_taken <= !rst && valid_in && !stall_in;
  end

  // Driver: offers requests at the falling edge, with random gaps.
  always @(negedge clk) begin
    vec_req_t r;
    if (!rst) begin
      // Drop the request that was taken at the last rising edge.
      if (in_taken) begin
        expected_results.push_back(predict_rescale('{x: in_x, y: in_y, len: target_length}));
        void'(pending_reqs.pop_front());
      end
      quiet_mode <= pending_reqs.size() < 200;
      if (pending_reqs.size() == 900 && !drain_pause && !(valid_in && !in_taken)) begin
        drain_pause <= 1'b1;
      end
      if (drain_pause && expected_results.size() == 0) drain_pause <= 1'b0;
      if (valid_in && !in_taken) begin
        // Payload holds while stalled.
      end else if (pending_reqs.size() == 0) begin
        valid_in <= 1'b0;
        stimulus_done <= 1'b1;
      end else if (drain_pause || send_gap > 0) begin
        valid_in <= 1'b0;
        if (send_gap > 0) send_gap <= send_gap - 1;
      end else if (!quiet_mode && $urandom_range(0, 9) == 0) begin
        valid_in <= 1'b0;
        send_gap <= $urandom_range(0, 17);
      end else begin
        r = pending_reqs[0];
        valid_in <= 1'b1;
        in_x <= r.x;
        in_y <= r.y;
        target_length <= r.len;
      end
    end
  end

  // Receiver back-pressure: random bursts, plus one long hold-off.
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_cycles == 0 && !long_hold_done && pending_reqs.size() <= 1400) begin
        hold_cycles <= 300;
        long_hold_done <= 1'b1;
        stall_out <= 1'b1;
      end else if (hold_cycles > 1) begin
        hold_cycles <= hold_cycles - 1;
      end else if (hold_cycles == 1) begin
        hold_cycles <= 0;
        stall_out <= 1'b0;
      end else if (quiet_mode) begin
        stall_out <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        if (recv_gap == 1) stall_out <= 1'b0;
      end else if ($urandom_range(0, 11) == 0) begin
        stall_out <= 1'b1;
        recv_gap <= $urandom_range(1, 18);
      end
    end
  end

  // Monitor: compares each accepted result with the oldest expectation.
  always @(posedge clk) begin
    vec_res_t e;
    if (!rst && valid_out && !stall_out) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("Result with no request pending: x=%0d y=%0d",
            out_x, out_y);
      end else begin
        e = expected_results.pop_front();
        if (out_x !== e.sx || out_y !== e.sy || ok !== e.good || vec_length !== e.mag) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("Mismatch: expected x=%0d y=%0d ok=%0d len=%0d", e.sx, e.sy, e.good,
                e.mag);
            $display("          actual   x=%0d y=%0d ok=%0d len=%0d", out_x, out_y, ok,
                vec_length);
          end
        end
      end
    end
  end

endmodule

// ===== vector_set_length.f =====
hw/rtl/vsl_pkg.sv
hw/rtl/vsl_sqrt_stage.sv
hw/rtl/vsl_div_stage.sv
hw/rtl/vector_set_length.sv
sim/vector_set_length_tb.sv
